>>> rtl/mac_grid_velocity_sampler_macros.svh
// Assertion macros used by the sampler controller
`ifndef MAC_GRID_VELOCITY_SAMPLER_MACROS_SVH
`define MAC_GRID_VELOCITY_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define MGVS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MGVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MGVS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MGVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/mgvs_pkg.sv
package mgvs_pkg;

    // grid size default
    localparam int GRID_N_DEF = 32;

    // field widths
    localparam int POS_W    = 16;
    localparam int CELL_W   = 32;
    localparam int VEL_W    = 32;
    localparam int IDX_IN_W = 6;
    localparam int COMP_W   = 2;

    // packed stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 96;

    // fixed point
    localparam int FRAC_BITS = 16;
    localparam int HALF_Q16  = 32768;
    localparam int ACC_W     = 40;   // blend intermediates, three levels of growth
    localparam int FW        = 18;   // fraction, up to 2.0 at the upper edge

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // component codes
    localparam logic [COMP_W-1:0] COMP_X = 2'd0;
    localparam logic [COMP_W-1:0] COMP_Y = 2'd1;
    localparam logic [COMP_W-1:0] COMP_Z = 2'd2;

    // corner and blend sequencing
    localparam int NUM_CORNERS = 8;
    localparam logic [2:0] LAST_CORNER = 3'd7;
    localparam logic [2:0] STEP_X00 = 3'd0;
    localparam logic [2:0] STEP_X10 = 3'd1;
    localparam logic [2:0] STEP_X01 = 3'd2;
    localparam logic [2:0] STEP_X11 = 3'd3;
    localparam logic [2:0] STEP_Y0  = 3'd4;
    localparam logic [2:0] STEP_Y1  = 3'd5;
    localparam logic [2:0] STEP_Z   = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       wr_en;
        logic       setup;
        logic       rd_en;
        logic [2:0] corner;
        logic       blend_en;
        logic [2:0] step;
        logic       out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

>>> rtl/mgvs_grid_mem.sv
module mgvs_grid_mem #(
    parameter int W  = 33,
    parameter int H  = 32,
    parameter int D  = 32,
    parameter int IW = 6
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [IW-1:0]                     wi,
    input  logic [IW-1:0]                     wj,
    input  logic [IW-1:0]                     wk,
    input  logic signed [mgvs_pkg::CELL_W-1:0] wdata,
    input  logic                              re,
    input  logic [IW-1:0]                     ri,
    input  logic [IW-1:0]                     rj,
    input  logic [IW-1:0]                     rk,
    output logic signed [mgvs_pkg::CELL_W-1:0] rdata
);

    localparam int DEPTH = W * H * D;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] H_A = AW'(H);
    localparam logic [AW-1:0] D_A = AW'(D);

    logic signed [mgvs_pkg::CELL_W-1:0] mem [0:DEPTH-1];
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic signed [mgvs_pkg::CELL_W-1:0] rdata_reg;

    // row-major address: (i*H + j)*D + k
    assign waddr = (AW'(wi) * H_A + AW'(wj)) * D_A + AW'(wk);
    assign raddr = (AW'(ri) * H_A + AW'(rj)) * D_A + AW'(rk);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mgvs_ctrl.sv
`include "mac_grid_velocity_sampler_macros.svh"

module mgvs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           query_req,
    input  mgvs_pkg::sts_t sts,
    output mgvs_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WRITE = 7'b0000010,
        ST_SETUP = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_BLEND = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_SPARE = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // sequencing: accept, then either one write or address setup, eight corner reads, seven blends, hand off
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (query_req == mgvs_pkg::OP_QUERY) ? ST_SETUP : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.wr_en  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                cmd.corner = cnt_reg;
                cnt_next   = cnt_reg + 3'd1;
                if (cnt_reg == mgvs_pkg::LAST_CORNER) begin
                    cnt_next   = '0;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                cmd.blend_en = 1'b1;
                cmd.step     = cnt_reg;
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == mgvs_pkg::STEP_Z) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    `MGVS_ASSERT_NEXT(a_query_setup, aclk, aresetn, s_tvalid && s_tready && query_req, state_reg == ST_SETUP)
    `MGVS_ASSERT_NEXT(a_blend_done, aclk, aresetn, state_reg == ST_BLEND && cnt_reg == mgvs_pkg::STEP_Z, state_reg == ST_DONE)
    `MGVS_ASSERT_NEXT(a_hold_busy, aclk, aresetn, state_reg == ST_DONE && sts.out_busy, state_reg == ST_DONE)
    `MGVS_ASSERT_IMPL(a_read_cnt, aclk, aresetn, state_reg == ST_READ, $past(state_reg) == ST_SETUP || $past(state_reg) == ST_READ)

endmodule

>>> rtl/mgvs_datapath.sv
module mgvs_datapath #(
    parameter int GRID_N = mgvs_pkg::GRID_N_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [mgvs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  mgvs_pkg::cmd_t                  cmd,
    output mgvs_pkg::sts_t                  sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mgvs_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IW  = $clog2(GRID_N + 1);
    localparam int CW  = mgvs_pkg::POS_W + $clog2(GRID_N + 1) + 2;
    localparam int FW  = mgvs_pkg::FW;
    localparam int AW  = mgvs_pkg::ACC_W;
    localparam int PW  = AW + FW + 2;
    localparam int CLW = mgvs_pkg::CELL_W;
    localparam int PSW = mgvs_pkg::POS_W;

    typedef struct packed {
        logic [IW-1:0] base;
        logic [FW-1:0] frac;
    } split_t;

    // clamp, floor and limit one axis coordinate
    function automatic split_t split_axis(logic [PSW-1:0] pos, int lim, logic off);
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] top;
        logic [CW-1:0]        b;
        split_t               r;
        c   = $signed(CW'(pos) * CW'(GRID_N)) - (off ? $signed(CW'(mgvs_pkg::HALF_Q16)) : '0);
        top = $signed(CW'(lim) << mgvs_pkg::FRAC_BITS);
        if (c < 0) c = '0;
        if (c > top) c = top;
        b = CW'(c) >> mgvs_pkg::FRAC_BITS;
        if (b > CW'(lim - 2)) b = CW'(lim - 2);
        r.base = IW'(b);
        r.frac = FW'(c - $signed(b << mgvs_pkg::FRAC_BITS));
        return r;
    endfunction

    // lo + round((hi - lo) * f / 2^16), halves toward +inf
    function automatic logic signed [AW-1:0] blend(logic signed [AW-1:0] lo,
                                                   logic signed [AW-1:0] hi,
                                                   logic [FW-1:0] f);
        logic signed [AW:0]   d;
        logic signed [PW-1:0] p;
        d = $signed((AW+1)'(hi)) - $signed((AW+1)'(lo));
        p = $signed(PW'(d)) * $signed(PW'(f));
        p = (p + $signed(PW'(mgvs_pkg::HALF_Q16))) >>> mgvs_pkg::FRAC_BITS;
        return lo + $signed(AW'(p));
    endfunction

    function automatic logic [mgvs_pkg::VEL_W-1:0] sat32(logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi_lim;
        logic signed [AW-1:0] lo_lim;
        hi_lim = $signed(AW'(32'h7fff_ffff));
        lo_lim = -hi_lim - $signed(AW'(1));
        if (v > hi_lim) return 32'h7fff_ffff;
        if (v < lo_lim) return 32'h8000_0000;
        return v[mgvs_pkg::VEL_W-1:0];
    endfunction

    // captured request
    logic [mgvs_pkg::COMP_W-1:0]   comp_reg;
    logic [mgvs_pkg::IDX_IN_W-1:0] ci_reg, cj_reg, ck_reg;
    logic signed [CLW-1:0]         val_reg;
    logic [PSW-1:0]                pos_reg [3];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            comp_reg   <= s_tdata[1:0];
            ci_reg     <= s_tdata[7:2];
            cj_reg     <= s_tdata[13:8];
            ck_reg     <= s_tdata[19:14];
            val_reg    <= $signed(s_tdata[51:20]);
            pos_reg[0] <= s_tdata[67:52];
            pos_reg[1] <= s_tdata[83:68];
            pos_reg[2] <= s_tdata[99:84];
        end
    end

    // per-grid base index and fraction
    logic [IW-1:0] base_reg [3][3];
    logic [FW-1:0] frac_reg [3][3];

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            for (int g = 0; g < 3; g++) begin
                for (int a = 0; a < 3; a++) begin
                    split_t s;
                    s = split_axis(pos_reg[a], (a == g) ? GRID_N + 1 : GRID_N, a != g);
                    base_reg[g][a] <= s.base;
                    frac_reg[g][a] <= s.frac;
                end
            end
        end
    end

    // corner capture in the cycle after each read
    logic       cap_en_reg;
    logic [2:0] cap_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_en_reg <= 1'b0;
        end else begin
            cap_en_reg <= cmd.rd_en;
        end
        cap_idx_reg <= cmd.corner;
    end

    logic signed [CLW-1:0] rdata [3];
    logic signed [CLW-1:0] corner_reg [3][mgvs_pkg::NUM_CORNERS];
    logic signed [AW-1:0]  t_reg [3][7];

    for (genvar g = 0; g < 3; g++) begin : g_grid
        localparam int GW = (g == 0) ? GRID_N + 1 : GRID_N;
        localparam int GH = (g == 1) ? GRID_N + 1 : GRID_N;
        localparam int GD = (g == 2) ? GRID_N + 1 : GRID_N;

        logic          we;
        logic [IW-1:0] ri, rj, rk;

        // drop writes outside this grid
        assign we = cmd.wr_en && (comp_reg == mgvs_pkg::COMP_W'(g))
                 && (int'(ci_reg) < GW) && (int'(cj_reg) < GH) && (int'(ck_reg) < GD);

        // corner bit 0 steps i, bit 1 steps j, bit 2 steps k
        assign ri = base_reg[g][0] + IW'(cmd.corner[0]);
        assign rj = base_reg[g][1] + IW'(cmd.corner[1]);
        assign rk = base_reg[g][2] + IW'(cmd.corner[2]);

        mgvs_grid_mem #(
            .W  (GW),
            .H  (GH),
            .D  (GD),
            .IW (IW)
        ) u_mem (
            .aclk  (aclk),
            .we    (we),
            .wi    (IW'(ci_reg)),
            .wj    (IW'(cj_reg)),
            .wk    (IW'(ck_reg)),
            .wdata (val_reg),
            .re    (cmd.rd_en),
            .ri    (ri),
            .rj    (rj),
            .rk    (rk),
            .rdata (rdata[g])
        );

        always_ff @(posedge aclk) begin
            if (cap_en_reg) begin
                corner_reg[g][cap_idx_reg] <= rdata[g];
            end
        end

        // operand select for the shared blend unit
        logic signed [AW-1:0] op_lo, op_hi;
        logic [FW-1:0]        op_f;

        always_comb begin
            op_lo = '0;
            op_hi = '0;
            op_f  = frac_reg[g][0];
            case (cmd.step)
                mgvs_pkg::STEP_X00: begin
                    op_lo = AW'(corner_reg[g][0]);
                    op_hi = AW'(corner_reg[g][1]);
                end
                mgvs_pkg::STEP_X10: begin
                    op_lo = AW'(corner_reg[g][2]);
                    op_hi = AW'(corner_reg[g][3]);
                end
                mgvs_pkg::STEP_X01: begin
                    op_lo = AW'(corner_reg[g][4]);
                    op_hi = AW'(corner_reg[g][5]);
                end
                mgvs_pkg::STEP_X11: begin
                    op_lo = AW'(corner_reg[g][6]);
                    op_hi = AW'(corner_reg[g][7]);
                end
                mgvs_pkg::STEP_Y0: begin
                    op_lo = t_reg[g][0];
                    op_hi = t_reg[g][1];
                    op_f  = frac_reg[g][1];
                end
                mgvs_pkg::STEP_Y1: begin
                    op_lo = t_reg[g][2];
                    op_hi = t_reg[g][3];
                    op_f  = frac_reg[g][1];
                end
                mgvs_pkg::STEP_Z: begin
                    op_lo = t_reg[g][4];
                    op_hi = t_reg[g][5];
                    op_f  = frac_reg[g][2];
                end
                default: begin
                    op_lo = '0;
                    op_hi = '0;
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            if (cmd.blend_en && cmd.step <= mgvs_pkg::STEP_Z) begin
                t_reg[g][cmd.step] <= blend(op_lo, op_hi, op_f);
            end
        end
    end

    // output register
    logic                              m_valid_reg;
    logic [mgvs_pkg::M_TDATA_W-1:0]    m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg <= {sat32(t_reg[2][6]), sat32(t_reg[1][6]), sat32(t_reg[0][6])};
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;
    assign sts.out_busy = m_valid_reg && !m_tready;

endmodule

>>> rtl/mac_grid_velocity_sampler.sv
// Channel | Dir | tdata fields (low bit up)                                | tuser
// s_      | in  | component, cell_i, cell_j, cell_k, cell_value, pos_x/y/z | operation
// m_      | out | vel_x, vel_y, vel_z                                      | -
//
// After a write request is accepted, the write state runs before the next accept.
// A query runs through accept, index setup, eight corner reads on the
// single read port of each grid memory, seven blends on one multiplier per grid.
// The three grids are read and blended in parallel.
// Reset clears control only; grid contents are undefined until written.
// A finished result waits in the output register; input is accepted meanwhile.
module mac_grid_velocity_sampler #(
    parameter int GRID_N = mgvs_pkg::GRID_N_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // component, cell_i, cell_j, cell_k, cell_value, pos_x, pos_y, pos_z, zero fill
    input  logic [mgvs_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // vel_x, vel_y, vel_z
    output logic [mgvs_pkg::M_TDATA_W-1:0] m_tdata
);

    mgvs_pkg::cmd_t cmd;
    mgvs_pkg::sts_t sts;

    mgvs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .query_req (s_tuser),
        .sts       (sts),
        .cmd       (cmd)
    );

    mgvs_datapath #(
        .GRID_N (GRID_N)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
